// ===== rtl/core/rapp_pkg.sv =====
// Shared widths, register map and reset values for the rotate-and-project block.
package rapp_pkg;

	localparam int COORD_W = 16;
	localparam int TRIG_W = 16;
	localparam int TRIG_FRAC = 14;
	localparam int SCR_W = 12;
	localparam int SIZE_W = 6;
	localparam int OSIZE_W = 12;

	// Rotation intermediates
	localparam int PROD_W = COORD_W + TRIG_W;
	localparam int T_W = PROD_W + 1;
	localparam int TP_W = T_W + TRIG_W;
	localparam int TSH_W = TP_W - TRIG_FRAC;
	localparam int DEPTH_W = TSH_W + 1;

	// Divider: visible depth fits DEN_W bits, quotient saturates past QUO_W bits
	localparam int DEN_W = 27;
	localparam int QUO_W = 17;
	localparam int NUM_W = 49;
	localparam int DIV_LAT = QUO_W + 1;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(10 * (1 << TRIG_FRAC));
	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(5000 * (1 << TRIG_FRAC));

	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_COS_YAW   = 3'd0;
	localparam logic [2:0] REG_SIN_YAW   = 3'd1;
	localparam logic [2:0] REG_COS_PITCH = 3'd2;
	localparam logic [2:0] REG_SIN_PITCH = 3'd3;
	localparam logic [2:0] REG_HALF_W    = 3'd4;
	localparam logic [2:0] REG_HALF_H    = 3'd5;
	localparam logic [2:0] REG_FOCAL     = 3'd6;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC);
	localparam logic [SCR_W-1:0] HALF_W_RST = SCR_W'(400);
	localparam logic [SCR_W-1:0] HALF_H_RST = SCR_W'(300);
	localparam logic [SCR_W-1:0] FOCAL_RST  = SCR_W'(500);

endpackage

// ===== rtl/core/rotate_and_project_point.sv =====
// Top level: register file, rotation and projection pipeline, output register.
// Rotates each point by yaw then pitch and projects it through a pinhole camera. One point
// enters per clock unless the output stalls, through six arithmetic stages, the 18-stage
// divider with an overflow check stage and one stage per quotient bit, and the output
// register. All stages advance together while the output register is empty or being taken;
// s_tready is that condition. Points outside depth 10..5000 get visible low, zero coordinates.
module rotate_and_project_point (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [55:0]                 s_tdata,  // pos_x, pos_y, pos_z, obj_size, zero pad
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata,  // screen_x, screen_y, screen_size, zero pad
	output logic                        m_tuser,  // visible
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rapp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rapp_pkg::*;

	logic signed [TRIG_W-1:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
	logic [SCR_W-1:0] half_w_q, half_h_q, focal_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_yaw_q <= TRIG_ONE;
			sin_yaw_q <= '0;
			cos_pitch_q <= TRIG_ONE;
			sin_pitch_q <= '0;
			half_w_q <= HALF_W_RST;
			half_h_q <= HALF_H_RST;
			focal_q <= FOCAL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COS_YAW:   cos_yaw_q <= pwdata[TRIG_W-1:0];
				REG_SIN_YAW:   sin_yaw_q <= pwdata[TRIG_W-1:0];
				REG_COS_PITCH: cos_pitch_q <= pwdata[TRIG_W-1:0];
				REG_SIN_PITCH: sin_pitch_q <= pwdata[TRIG_W-1:0];
				REG_HALF_W:    half_w_q <= pwdata[SCR_W-1:0];
				REG_HALF_H:    half_h_q <= pwdata[SCR_W-1:0];
				REG_FOCAL:     focal_q <= pwdata[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COS_YAW:   prdata = 32'(cos_yaw_q);
			REG_SIN_YAW:   prdata = 32'(sin_yaw_q);
			REG_COS_PITCH: prdata = 32'(cos_pitch_q);
			REG_SIN_PITCH: prdata = 32'(sin_pitch_q);
			REG_HALF_W:    prdata = {20'b0, half_w_q};
			REG_HALF_H:    prdata = {20'b0, half_h_q};
			REG_FOCAL:     prdata = {20'b0, focal_q};
			default:       prdata = '0;
		endcase
	end

	// Pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_d [0:DIV_LAT-1];

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic signed [COORD_W-1:0] in_x, in_y, in_z;
	assign in_x = s_tdata[15:0];
	assign in_y = s_tdata[31:16];
	assign in_z = s_tdata[47:32];

	// Stage 1: first-round products
	logic signed [PROD_W-1:0] xcy_s1, ysy_s1, xsy_s1, ycy_s1, zsp_s1, zcp_s1;
	logic [SIZE_W-1:0] size_s1;
	// Stage 2: yaw rotation
	logic signed [T_W-1:0] tx_s2, ty_s2;
	logic signed [PROD_W-1:0] zsp_s2, zcp_s2;
	logic [SIZE_W-1:0] size_s2;
	// Stage 3: pitch products
	logic signed [TP_W-1:0] txcp_s3, txsp_s3;
	logic signed [T_W-1:0] ty_s3;
	logic signed [PROD_W-1:0] zsp_s3, zcp_s3;
	logic [SIZE_W-1:0] size_s3;
	// Stage 4: depth, vertical offset, visibility
	logic signed [DEPTH_W-1:0] depth_s4, vz_s4;
	logic signed [T_W-1:0] ty_s4;
	logic [SIZE_W-1:0] size_s4;
	logic vis_s4;
	// Stage 5: projection products
	logic [DEN_W+SCR_W-1:0] hwd_s5, hhd_s5;
	logic signed [T_W+SCR_W:0] tyf_s5;
	logic signed [DEPTH_W+SCR_W:0] vzf_s5;
	logic [SIZE_W+SCR_W-1:0] szf_s5;
	logic [DEN_W-1:0] den_s5;
	logic vis_s5;
	// Stage 6: signed numerators folded to magnitudes
	logic [NUM_W-1:0] magx_s6, magy_s6, mags_s6;
	logic [DEN_W-1:0] den_s6;
	logic negx_s6, negy_s6, vis_s6;

	logic signed [TSH_W-1:0] txcp_sh, txsp_sh;
	logic signed [DEPTH_W-1:0] depth_c, vz_c;
	logic signed [NUM_W:0] numx_c, numy_c;

	assign txcp_sh = txcp_s3[TP_W-1:TRIG_FRAC];
	assign txsp_sh = txsp_s3[TP_W-1:TRIG_FRAC];
	assign depth_c = DEPTH_W'(txcp_sh) + DEPTH_W'(zsp_s3);
	assign vz_c = DEPTH_W'(zcp_s3) - DEPTH_W'(txsp_sh);
	assign numx_c = $signed({{(NUM_W+1-DEN_W-SCR_W){1'b0}}, hwd_s5}) + (NUM_W+1)'(tyf_s5);
	assign numy_c = $signed({{(NUM_W+1-DEN_W-SCR_W){1'b0}}, hhd_s5}) + (NUM_W+1)'(vzf_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			xcy_s1 <= in_x * cos_yaw_q;
			ysy_s1 <= in_y * sin_yaw_q;
			xsy_s1 <= in_x * sin_yaw_q;
			ycy_s1 <= in_y * cos_yaw_q;
			zsp_s1 <= in_z * sin_pitch_q;
			zcp_s1 <= in_z * cos_pitch_q;
			size_s1 <= s_tdata[53:48];

			tx_s2 <= T_W'(xcy_s1) - T_W'(ysy_s1);
			ty_s2 <= T_W'(xsy_s1) + T_W'(ycy_s1);
			zsp_s2 <= zsp_s1;
			zcp_s2 <= zcp_s1;
			size_s2 <= size_s1;

			txcp_s3 <= TP_W'(tx_s2) * TP_W'(cos_pitch_q);
			txsp_s3 <= TP_W'(tx_s2) * TP_W'(sin_pitch_q);
			ty_s3 <= ty_s2;
			zsp_s3 <= zsp_s2;
			zcp_s3 <= zcp_s2;
			size_s3 <= size_s2;

			depth_s4 <= depth_c;
			vz_s4 <= vz_c;
			ty_s4 <= ty_s3;
			size_s4 <= size_s3;
			vis_s4 <= (depth_c >= DEPTH_MIN) && (depth_c <= DEPTH_MAX);

			hwd_s5 <= (DEN_W+SCR_W)'(depth_s4[DEN_W-1:0]) * (DEN_W+SCR_W)'(half_w_q);
			hhd_s5 <= (DEN_W+SCR_W)'(depth_s4[DEN_W-1:0]) * (DEN_W+SCR_W)'(half_h_q);
			tyf_s5 <= (T_W+SCR_W+1)'(ty_s4) * $signed({1'b0, focal_q});
			vzf_s5 <= (DEPTH_W+SCR_W+1)'(vz_s4) * $signed({1'b0, focal_q});
			szf_s5 <= (SIZE_W+SCR_W)'(size_s4) * (SIZE_W+SCR_W)'(focal_q);
			den_s5 <= depth_s4[DEN_W-1:0];
			vis_s5 <= vis_s4;

			negx_s6 <= numx_c[NUM_W];
			negy_s6 <= numy_c[NUM_W];
			magx_s6 <= numx_c[NUM_W] ? NUM_W'(-numx_c) : numx_c[NUM_W-1:0];
			magy_s6 <= numy_c[NUM_W] ? NUM_W'(-numy_c) : numy_c[NUM_W-1:0];
			mags_s6 <= NUM_W'({szf_s5, {TRIG_FRAC{1'b0}}});
			den_s6 <= den_s5;
			vis_s6 <= vis_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) v_d[k] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_d[0] <= v_s6;
			for (int k = 1; k < DIV_LAT; k++) v_d[k] <= v_d[k-1];
			m_tvalid <= v_d[DIV_LAT-1];
		end
	end

	// Side data riding alongside the dividers
	logic vis_d [0:DIV_LAT-1];
	logic negx_d [0:DIV_LAT-1];
	logic negy_d [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_d[0] <= vis_s6;
			negx_d[0] <= negx_s6;
			negy_d[0] <= negy_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				vis_d[k] <= vis_d[k-1];
				negx_d[k] <= negx_d[k-1];
				negy_d[k] <= negy_d[k-1];
			end
		end
	end

	logic [QUO_W-1:0] qx, qy, qs;
	logic ox, oy, os;

	rapp_div u_div_x (.clk, .en(adv), .num(magx_s6), .den(den_s6), .quo(qx), .ovf(ox));
	rapp_div u_div_y (.clk, .en(adv), .num(magy_s6), .den(den_s6), .quo(qy), .ovf(oy));
	rapp_div u_div_s (.clk, .en(adv), .num(mags_s6), .den(den_s6), .quo(qs), .ovf(os));

	function automatic logic [15:0] clamp_coord(input logic [QUO_W-1:0] q, input logic o,
			input logic neg);
		logic [QUO_W-1:0] m;
		m = o ? '1 : q;
		if (neg) begin
			clamp_coord = (m >= QUO_W'(32768)) ? 16'h8000 : 16'(-m[15:0]);
		end else begin
			clamp_coord = (m > QUO_W'(32767)) ? 16'h7FFF : m[15:0];
		end
	endfunction

	logic vis_o;
	logic [15:0] sx_c, sy_c;
	logic [OSIZE_W-1:0] ss_c;

	assign vis_o = vis_d[DIV_LAT-1];
	assign sx_c = vis_o ? clamp_coord(qx, ox, negx_d[DIV_LAT-1]) : '0;
	assign sy_c = vis_o ? clamp_coord(qy, oy, negy_d[DIV_LAT-1]) : '0;
	assign ss_c = !vis_o ? '0 : ((os || qs > QUO_W'(4095)) ? '1 : qs[OSIZE_W-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {4'b0, ss_c, sy_c, sx_c};
			m_tuser <= vis_o;
		end
	end

	// Hidden points carry no coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("hidden point with nonzero coordinates");

	// A stall freezes the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_d[DIV_LAT-1]))
		else $error("pipeline moved during stall");

	// A focal length write lands in the register.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && reg_idx == REG_FOCAL |=> focal_q == $past(pwdata[SCR_W-1:0]))
		else $error("focal length write lost");

endmodule

// ===== rtl/core/rapp_div.sv =====
// Pipelined restoring divider with an overflow flag, one quotient bit per stage.
module rapp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rapp_pkg::NUM_W-1:0]    num,
	input  logic [rapp_pkg::DEN_W-1:0]    den,
	output logic [rapp_pkg::QUO_W-1:0]    quo,
	output logic                          ovf
);
	import rapp_pkg::*;

	logic [DEN_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] bits_s [0:QUO_W];
	logic             ovf_s [0:QUO_W];

	logic [DEN_W:0] trial [1:QUO_W];
	logic           ge [1:QUO_W];
	logic [DEN_W:0] diff [1:QUO_W];

	always_comb begin
		for (int k = 1; k <= QUO_W; k++) begin
			trial[k] = {rem_s[k-1], bits_s[k-1][QUO_W-1]};
			ge[k] = trial[k] >= {1'b0, den_s[k-1]};
			diff[k] = trial[k] - {1'b0, den_s[k-1]};
		end
	end

	// Low numerator bits shift out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= num[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den);
			rem_s[0] <= num[QUO_W+DEN_W-1:QUO_W];
			bits_s[0] <= num[QUO_W-1:0];
			den_s[0] <= den;
			for (int k = 1; k <= QUO_W; k++) begin
				ovf_s[k] <= ovf_s[k-1];
				den_s[k] <= den_s[k-1];
				rem_s[k] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
				bits_s[k] <= {bits_s[k-1][QUO_W-2:0], ge[k]};
			end
		end
	end

	assign quo = bits_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule
